[hdl/hmpq_pkg.sv]
`timescale 1ns / 1ps

package hmpq_pkg;

    localparam int KEY_W     = 32;
    localparam int CNT_W     = 11;
    localparam int DEPTH_DEF = 1024;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] min_key;
        logic                    vacant;
        logic [CNT_W-1:0]        entry_count;
        t_status                 status;
    } t_result;

endpackage

[hdl/min_heap_priority_queue_top.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       to block   i_in_valid / o_in_stall   i_kind, i_key
// out      from block o_out_valid / i_out_stall o_min_key, o_vacant, o_entry_count, o_status
//
// One item at a time: a push climbs and a pop descends the heap level by level, with
// one read then compare-and-write pair on the heap store per level. Full pushes,
// empty pops and pops of the last entry go straight to the result.
// Synchronous active-low reset empties the heap; the store itself is not cleared.
// A result held by i_out_stall stalls the engine once its next result is ready, before a further item is taken.

module min_heap_priority_queue_top #(
    parameter int HEAP_DEPTH = hmpq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic signed [hmpq_pkg::KEY_W-1:0] i_key,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [hmpq_pkg::KEY_W-1:0] o_min_key,
    output logic                              o_vacant,
    output logic [hmpq_pkg::CNT_W-1:0]        o_entry_count,
    output logic [1:0]                        o_status
);
    import hmpq_pkg::*;

    logic    idle, res_valid, res_take;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    hmpq_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && idle),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_res_take  (res_take),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_in_stall    = !idle;
    assign o_out_valid   = r_out_valid;
    assign o_min_key     = r_out.min_key;
    assign o_vacant      = r_out.vacant;
    assign o_entry_count = r_out.entry_count;
    assign o_status      = r_out.status;

    a_empty_min_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vacant |-> o_min_key == '0)
        else $error("empty heap reports non-zero minimum");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == CNT_W'(HEAP_DEPTH))
        else $error("dropped push without a full heap");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_vacant)
        else $error("empty pop with entries present");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("engine idle straight after taking an item");

endmodule

[hdl/hmpq_mem.sv]
`timescale 1ns / 1ps

module hmpq_mem #(
    parameter int DEPTH = hmpq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [hmpq_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr_a,
    input  logic [AW-1:0]            i_raddr_b,
    output logic [hmpq_pkg::KEY_W-1:0] o_rdata_a,
    output logic [hmpq_pkg::KEY_W-1:0] o_rdata_b
);
    import hmpq_pkg::*;

    logic [KEY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[hdl/hmpq_ctrl.sv]
`timescale 1ns / 1ps

module hmpq_ctrl #(
    parameter int HEAP_DEPTH = hmpq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_kind,
    input  logic signed [hmpq_pkg::KEY_W-1:0] i_key,
    input  logic                          i_res_take,
    output logic                          o_idle,
    output logic                          o_res_valid,
    output hmpq_pkg::t_result             o_res
);
    import hmpq_pkg::*;

    localparam int PW = $clog2(HEAP_DEPTH + 1);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(HEAP_DEPTH);
    localparam logic [PW-1:0] POS_ROOT = PW'(1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_RD  = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_LAST   = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [PW-1:0]           r_occ, n_occ;
    logic [PW-1:0]           r_pos, n_pos;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_root, n_root;
    t_status                 r_status, n_status;

    logic                    mem_we;
    logic [PW-1:0]           wr_pos;
    logic [KEY_W-1:0]        mem_wdata;
    logic [AW-1:0]           mem_raddr_a, mem_raddr_b;
    logic [KEY_W-1:0]        rd_a, rd_b;
    logic signed [KEY_W-1:0] val_a, val_b, pick_val;
    logic [PW:0]             left, left_p1, occ_x;
    logic [PW-1:0]           pos_m1, occ_m1;
    logic                    take_right;

    hmpq_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (pos_m1[AW-1:0]),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign val_a   = $signed(rd_a);
    assign val_b   = $signed(rd_b);
    assign left    = {r_pos, 1'b0};
    assign left_p1 = left + 1'b1;
    assign occ_x   = {1'b0, r_occ};
    assign pos_m1  = wr_pos - 1'b1;
    assign occ_m1  = r_occ - 1'b1;
    // left child wins ties
    assign take_right = (left_p1 <= occ_x) && (val_b < val_a);
    assign pick_val   = take_right ? val_b : val_a;

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_pos       = r_pos;
        n_key       = r_key;
        n_root      = r_root;
        n_status    = r_status;
        mem_we      = 1'b0;
        wr_pos      = r_pos;
        mem_wdata   = r_key;
        mem_raddr_a = occ_m1[AW-1:0];
        mem_raddr_b = left[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_OK;
                    if (i_kind == KIND_PUSH) begin
                        if (r_occ >= DEPTH_P) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_occ   = r_occ + 1'b1;
                            n_pos   = r_occ + 1'b1;
                            n_key   = i_key;
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (r_occ == POS_ROOT) begin
                            n_occ   = '0;
                            n_state = S_DONE;
                        end else begin
                            // fetch the last entry; it refills the root
                            n_occ   = occ_m1;
                            n_state = S_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == POS_ROOT) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    wr_pos      = r_pos >> 1;
                    mem_raddr_a = pos_m1[AW-1:0];
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_key < val_a) begin
                    mem_wdata = rd_a;
                    n_pos     = r_pos >> 1;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LAST: begin
                n_key   = val_a;
                n_pos   = POS_ROOT;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (left > occ_x) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr_a = AW'(left - 1'b1);
                    mem_raddr_b = left[AW-1:0];
                    n_state     = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (pick_val < r_key) begin
                    mem_wdata = pick_val;
                    n_pos     = take_right ? left_p1[PW-1:0] : left[PW-1:0];
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (mem_we && wr_pos == POS_ROOT) begin
            n_root = $signed(mem_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_root   <= n_root;
        r_status <= n_status;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.vacant      = (r_occ == '0);
        o_res.min_key     = o_res.vacant ? '0 : r_root;
        o_res.entry_count = CNT_W'(r_occ);
        o_res.status      = r_status;
    end

endmodule

[bench/tb_min_heap_priority_queue_top.sv]
`timescale 1ns / 1ps

module tb_min_heap_priority_queue_top;
    import hmpq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 64;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_kind;
    logic signed [KEY_W-1:0] i_key;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [KEY_W-1:0] o_min_key;
    logic                    o_vacant;
    logic [CNT_W-1:0]        o_entry_count;
    logic [1:0]              o_status;

    min_heap_priority_queue_top #(
        .HEAP_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_min_key     (o_min_key),
        .o_vacant      (o_vacant),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    // Shadow heap: predicts min, count and status for each accepted item.
    class heap_tracker;
        logic signed [KEY_W-1:0] keys [1:DEPTH];
        int unsigned             fill;
        t_result                 pending_results [$];
        int unsigned             errors;
        int unsigned             empty_hits;

        function new();
            fill       = 0;
            errors     = 0;
            empty_hits = 0;
        endfunction

        function void swap_keys(int unsigned a, int unsigned b);
            logic signed [KEY_W-1:0] t;
            t       = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void note_op(logic kind, logic signed [KEY_W-1:0] key);
            t_result     r;
            int unsigned pos;
            int unsigned pick;
            r.status = ST_OK;
            if (kind == KIND_PUSH) begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    fill++;
                    keys[fill] = key;
                    pos = fill;
                    // climbs only while strictly smaller than the parent
                    while (pos > 1 && keys[pos] < keys[pos / 2]) begin
                        swap_keys(pos, pos / 2);
                        pos = pos / 2;
                    end
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    keys[1] = keys[fill];
                    fill--;
                    pos = 1;
                    while (2 * pos <= fill) begin
                        pick = 2 * pos;
                        // left child wins a tie
                        if (pick + 1 <= fill && keys[pick + 1] < keys[pick])
                            pick = pick + 1;
                        if (!(keys[pick] < keys[pos]))
                            break;
                        swap_keys(pos, pick);
                        pos = pick;
                    end
                end
            end
            r.min_key     = (fill != 0) ? keys[1] : '0;
            r.vacant      = (fill == 0);
            r.entry_count = fill[CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(logic signed [KEY_W-1:0] mk, logic emp,
                          logic [CNT_W-1:0] cnt, logic [1:0] st);
            t_result e;
            if (pending_results.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            e = pending_results.pop_front();
            if (mk !== e.min_key)
                report($sformatf("min_key %0d, want %0d", mk, e.min_key));
            if (emp !== e.vacant)
                report($sformatf("vacant %b, want %b", emp, e.vacant));
            if (cnt !== e.entry_count)
                report($sformatf("entry_count %0d, want %0d", cnt, e.entry_count));
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
        endtask
    endclass

    heap_tracker sb = new();

    bit calm;
    int hold_reqs;
    int holds_done;
    int stuck;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        holds_done  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_reqs) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_min_key, o_vacant, o_entry_count, o_status);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck <= 0;
        end else if (stuck + 1 >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            // narrow range so equal keys meet in the heap
            1, 2, 3: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
            default: return $signed($urandom());
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic kind, logic signed [KEY_W-1:0] key);
        while (!calm && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_op(kind, key);
        @(negedge i_clk);
    endtask

    task automatic send_random(int push_pct);
        logic kind;
        kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
        send_item(kind, rand_key());
    endtask

    initial begin
        int unsigned empties;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_kind     = KIND_PUSH;
        i_key      = '0;
        calm       = 1'b0;
        hold_reqs  = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: pop on empty, key extremes, equal keys, drain past empty
        send_item(KIND_POP, $signed($urandom()));
        send_item(KIND_PUSH, 32'sh7FFF_FFFF);
        send_item(KIND_PUSH, 32'sh8000_0000);
        send_item(KIND_PUSH, 32'sh0000_0000);
        send_item(KIND_PUSH, -32'sd1);
        send_item(KIND_PUSH, 32'sd1);
        send_item(KIND_PUSH, 32'sh8000_0000);
        send_item(KIND_PUSH, 32'sh7FFF_FFFF);
        send_item(KIND_PUSH, 32'sd5);
        send_item(KIND_PUSH, 32'sd5);
        repeat (10) send_item(KIND_POP, $signed($urandom()));

        repeat (120) send_random(55);
        hold_reqs++;
        repeat (80) send_random(55);

        // push-heavy run to build a deep heap, held off halfway
        repeat (150) send_random(95);
        hold_reqs++;
        repeat (150) send_random(95);

        // a stretch with no idling on either side
        calm = 1'b1;
        repeat (200) send_random(5);
        calm = 1'b0;

        empties = sb.empty_hits;
        while (sb.empty_hits < empties + 8)
            send_random(5);

        repeat (80) send_random(50);
        i_in_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
